@@ sv/csim_pkg.sv @@
package csim_pkg;

  localparam int LANES   = 4;
  localparam int EW      = 16;
  localparam int CW      = 3;
  localparam int DOT_W   = 44;
  localparam int SQ_W    = 43;
  localparam int MAG_W   = 44;
  localparam int HALF_W  = MAG_W / 2;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int WIDE_W  = 122;
  localparam int RES_W   = 16;
  localparam int R_W     = RES_W + 1;
  localparam int STEP_W  = 4;
  localparam int MCNT_W  = 4;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int LSUM_W  = 2 * EW + 2;
  localparam int ACC_X_W = DOT_W + 2;

  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [SQ_W-1:0]         SQ_MAX  = '1;
  localparam logic [R_W-1:0]          R_CAP   = R_W'(1) << (RES_W - 1);
  localparam logic [RES_W-1:0]        POS_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [MCNT_W-1:0]       MUL_STEPS = MCNT_W'(8);
  localparam logic [STEP_W-1:0]       TOP_STEP  = STEP_W'(RES_W - 1);

  // accumulated sums of one vector pair
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         sqa;
    logic [SQ_W-1:0]         sqb;
  } acc_t;

endpackage

@@ sv/csim_front.sv @@
module csim_front (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [csim_pkg::LANES-1:0][csim_pkg::EW-1:0] a_lanes,
  input  logic [csim_pkg::LANES-1:0][csim_pkg::EW-1:0] b_lanes,
  input  logic [csim_pkg::CW-1:0]                      lane_count,
  input  logic                                         last_item,
  output logic                                         q_push,
  input  logic                                         q_ready,
  output csim_pkg::acc_t                               q_data
);
  import csim_pkg::*;

  logic [LANES-1:0][2*EW-1:0] pd_r, pa_r, pb_r;
  logic [LANES-1:0][2*EW-1:0] pd_nxt, pa_nxt, pb_nxt;
  logic                       s1_valid_r, s1_last_r;
  acc_t                       acc_r, acc_nxt;
  logic                       drain;
  logic signed [LSUM_W-1:0]   dsum;
  logic [LSUM_W-1:0]          qa_sum, qb_sum;
  logic signed [ACC_X_W-1:0]  dot_x;
  logic [ACC_X_W-1:0]         sqa_x, sqb_x;

  // per-lane products, masked by lane count
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (CW'(i) < lane_count) begin
        pd_nxt[i] = $signed(a_lanes[i]) * $signed(b_lanes[i]);
        pa_nxt[i] = $signed(a_lanes[i]) * $signed(a_lanes[i]);
        pb_nxt[i] = $signed(b_lanes[i]) * $signed(b_lanes[i]);
      end else begin
        pd_nxt[i] = '0;
        pa_nxt[i] = '0;
        pb_nxt[i] = '0;
      end
    end
  end

  // lane sums and saturating accumulate
  always_comb begin
    dsum   = '0;
    qa_sum = '0;
    qb_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      dsum   = dsum + LSUM_W'($signed(pd_r[i]));
      qa_sum = qa_sum + LSUM_W'(pa_r[i]);
      qb_sum = qb_sum + LSUM_W'(pb_r[i]);
    end
    dot_x = ACC_X_W'(acc_r.dot) + ACC_X_W'(dsum);
    sqa_x = ACC_X_W'(acc_r.sqa) + ACC_X_W'(qa_sum);
    sqb_x = ACC_X_W'(acc_r.sqb) + ACC_X_W'(qb_sum);
    if (dot_x > ACC_X_W'(DOT_MAX)) begin
      acc_nxt.dot = DOT_MAX;
    end else if (dot_x < ACC_X_W'(DOT_MIN)) begin
      acc_nxt.dot = DOT_MIN;
    end else begin
      acc_nxt.dot = dot_x[DOT_W-1:0];
    end
    acc_nxt.sqa = (sqa_x > ACC_X_W'(SQ_MAX)) ? SQ_MAX : sqa_x[SQ_W-1:0];
    acc_nxt.sqb = (sqb_x > ACC_X_W'(SQ_MAX)) ? SQ_MAX : sqb_x[SQ_W-1:0];
  end

  assign drain    = !s1_last_r || q_ready;
  assign in_ready = !s1_valid_r || drain;
  assign q_push   = s1_valid_r && s1_last_r && q_ready;
  assign q_data   = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      acc_r      <= '0;
    end else begin
      if (s1_valid_r && drain) begin
        acc_r <= s1_last_r ? acc_t'('0) : acc_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
        s1_last_r  <= in_valid && last_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pd_r <= pd_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

endmodule

@@ sv/csim_fifo.sv @@
module csim_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  csim_pkg::acc_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output csim_pkg::acc_t pop_data,
  output logic           full
);
  import csim_pkg::*;

  acc_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign push_ready = !full;
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ sv/csim_back.sv @@
module csim_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  csim_pkg::acc_t             q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [csim_pkg::RES_W-1:0] out_similarity,
  output logic                       out_zero_norm
);
  import csim_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SRCH, ST_OUT} state_t;

  state_t                    state_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r, sa_r, sb_r;
  logic [MCNT_W-1:0]         cnt_r;
  logic [PROD_W-1:0]         prod_r, pacc_r, lacc_r, pp_shift;
  logic [HALF_W-1:0]         op_a, op_b;
  logic [MAG_W-1:0]          src_a, src_b;
  logic [2:0]                pj;
  logic [STEP_W-1:0]         k_r;
  logic [R_W-1:0]            r_r, cand_r, r_fin;
  logic signed [WIDE_W-1:0]  s2p_r, sp_r, p_w, l_w, cand_sp, cand_s2p;
  logic [5:0]                sh2;
  logic                      take;
  logic [RES_W-1:0]          sim_nxt;
  logic [MAG_W-1:0]          mag_nxt;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = (state_r == ST_OUT);

  assign mag_nxt = q_data.dot[DOT_W-1] ? MAG_W'(-q_data.dot) : MAG_W'(q_data.dot);

  // partial product select: first four build sa*sb, last four mag*mag
  always_comb begin
    src_a = cnt_r[2] ? mag_r : sa_r;
    src_b = cnt_r[2] ? mag_r : sb_r;
    op_a  = cnt_r[1] ? src_a[MAG_W-1:HALF_W] : src_a[HALF_W-1:0];
    op_b  = cnt_r[0] ? src_b[MAG_W-1:HALF_W] : src_b[HALF_W-1:0];
    pj    = 3'(cnt_r - 1'b1);
    case ({pj[1], pj[0]})
      2'b00:   pp_shift = prod_r;
      2'b11:   pp_shift = prod_r << (2 * HALF_W);
      default: pp_shift = prod_r << HALF_W;
    endcase
  end

  // one bit of the quotient search per cycle
  always_comb begin
    p_w      = $signed(WIDE_W'(pacc_r));
    l_w      = $signed(WIDE_W'(lacc_r) << (2 * 2 * EW / 2));
    sh2      = {1'b0, k_r, 1'b0} + 6'd2;
    cand_r   = r_r + (R_W'(1) << k_r);
    cand_sp  = sp_r + (p_w << ({2'b00, k_r} + 6'd1));
    cand_s2p = s2p_r + (sp_r << ({2'b00, k_r} + 6'd2)) + (p_w << sh2);
    take     = (cand_r <= R_CAP) && (cand_s2p <= l_w);
    r_fin    = take ? cand_r : r_r;
    if (neg_r) begin
      sim_nxt = RES_W'(-r_fin[RES_W-1:0]);
    end else begin
      sim_nxt = (r_fin > R_W'(POS_MAX)) ? POS_MAX : r_fin[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            neg_r  <= q_data.dot[DOT_W-1];
            mag_r  <= mag_nxt;
            sa_r   <= MAG_W'(q_data.sqa);
            sb_r   <= MAG_W'(q_data.sqb);
            cnt_r  <= '0;
            pacc_r <= '0;
            lacc_r <= '0;
            if (q_data.sqa == '0 || q_data.sqb == '0) begin
              out_similarity <= '0;
              out_zero_norm  <= 1'b1;
              state_r        <= ST_OUT;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r != '0) begin
            if (pj[2]) lacc_r <= lacc_r + pp_shift;
            else       pacc_r <= pacc_r + pp_shift;
          end
          if (cnt_r == MUL_STEPS) begin
            r_r     <= '0;
            s2p_r   <= p_w;
            sp_r    <= -p_w;
            k_r     <= TOP_STEP;
            state_r <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (take) begin
            r_r   <= cand_r;
            sp_r  <= cand_sp;
            s2p_r <= cand_s2p;
          end
          k_r <= k_r - 1'b1;
          if (k_r == '0) begin
            out_similarity <= sim_nxt;
            out_zero_norm  <= 1'b0;
            state_r        <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/cosine_similarity_engine_unit.sv @@
// cosine similarity of two streamed q1.15 vectors. each input beat carries up
// to four element pairs (the first lane_count lanes count, above four reads
// as four); beats are taken one per cycle while in_ready is high into a
// two-stage multiply and saturating accumulate front end. the beat with
// last_item set closes the pair: its sums go into a two-entry queue and the
// accumulators clear, so the next pair streams in at once. the back end turns
// each queued entry into one result, dot * 2^15 / sqrt(sumsq_a * sumsq_b)
// rounded half away from zero and clamped to q1.15: one 22x22 multiplier
// builds the two wide products, then a shift-and-add search settles one
// result bit per cycle, top bit first. a pair with a zero sum of squares
// gives 0 with zero_norm set, skipping both steps. input stalls only when the
// queue is full and a last beat waits, i.e. when pairs are shorter than the
// back end's latency.
module cosine_similarity_engine_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [csim_pkg::EW-1:0]   in_a_lane0,
  input  logic signed [csim_pkg::EW-1:0]   in_a_lane1,
  input  logic signed [csim_pkg::EW-1:0]   in_a_lane2,
  input  logic signed [csim_pkg::EW-1:0]   in_a_lane3,
  input  logic signed [csim_pkg::EW-1:0]   in_b_lane0,
  input  logic signed [csim_pkg::EW-1:0]   in_b_lane1,
  input  logic signed [csim_pkg::EW-1:0]   in_b_lane2,
  input  logic signed [csim_pkg::EW-1:0]   in_b_lane3,
  input  logic [csim_pkg::CW-1:0]          in_lane_count,
  input  logic                             in_last_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [csim_pkg::RES_W-1:0] out_similarity,
  output logic                             out_zero_norm
);
  import csim_pkg::*;

  logic [LANES-1:0][EW-1:0] a_lanes, b_lanes;
  logic                     q_push, q_ready, q_valid, q_pop, q_full;
  acc_t                     q_in, q_out;
  logic [RES_W-1:0]         sim;

  // lane packing
  assign a_lanes = {in_a_lane3, in_a_lane2, in_a_lane1, in_a_lane0};
  assign b_lanes = {in_b_lane3, in_b_lane2, in_b_lane1, in_b_lane0};

  // multiply and accumulate front end
  csim_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .a_lanes    (a_lanes),
    .b_lanes    (b_lanes),
    .lane_count (in_lane_count),
    .last_item  (in_last_item),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_data     (q_in)
  );

  // finished sums wait here while the back end works
  csim_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out),
    .full       (q_full)
  );

  // wide products, bitwise quotient search, result register
  csim_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_data         (q_out),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_similarity (sim),
    .out_zero_norm  (out_zero_norm)
  );

  assign out_similarity = $signed(sim);

`ifndef SYNTH
  // a zero norm always reports a zero similarity
  a_zero_norm_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_similarity == '0)
    else $error("zero norm with nonzero similarity");

  // the queue never takes a beat while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue push while full");

  // an input stall only comes from a closing beat blocked on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_full)
    else $error("input stalled without a full queue");
`endif

endmodule
